[rtl/kal_pkg.sv]
package kal_pkg;

    // Field widths
    localparam int MODE_W = 2;
    localparam int NODE_W = 10;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Store geometry
    localparam int MAX_NODES = 1024;
    localparam int LEVELS = 10;
    localparam int TOP = LEVELS - 1;
    localparam int LVL_W = $clog2(LEVELS);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int RAM_AW = LVL_W + NODE_AW;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Result kinds
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_BUILD = 1'b1;

    // Register index
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B0_RD,
        S_B0_WR,
        S_BA,
        S_BB,
        S_BC,
        S_Q,
        S_QW,
        S_OUT
    } t_state;

    function automatic logic [RAM_AW-1:0] ram_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [NODE_W-1:0] nd);
        return {lvl, NODE_AW'(nd)};
    endfunction

endpackage

[rtl/kal_ram.sv]
module kal_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kth_ancestor_binary_lifting_top.sv]
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: mode; tdata: node, value
// m_axis    out        tuser: kind; tdata: ancestor, found
// apb       in/out     node_count at byte address 0
//
// Load: written straight into level 0 of the jump store.
// Query: one jump per set bit of k below the top level, then one repeat of the top
//   level per unit of the high part; a climb that leaves the tree ends early.
// Build: two port accesses per level-0 entry, three per entry of each higher level.
//   i_rst_n is synchronous; the jump store has no reset.
// One item at a time; a finished result waits in the output register.
module kth_ancestor_binary_lifting_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kal_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // node, value, zero pad
    input  logic [kal_pkg::MODE_W-1:0]     s_axis_tuser,   // mode
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [kal_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // ancestor, found, zero pad
    output logic                           m_axis_tuser,   // kind
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kal_pkg::APB_AW-1:0]     paddr,
    input  logic [kal_pkg::APB_DW-1:0]     pwdata,
    output logic [kal_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    import kal_pkg::*;

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_node_count, n_node_count;
    logic                r_table_ready, n_table_ready;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [NODE_W-1:0]   r_j, n_j;
    logic [NODE_W-1:0]   r_a, n_a;       // current climb position / result
    logic [NODE_W-1:0]   r_k, n_k;       // remaining distance bits
    logic                r_res_kind, n_res_kind;
    logic                r_out_valid, n_out_valid;
    logic                r_out_kind, n_out_kind;
    logic [NODE_W-1:0]   r_out_anc, n_out_anc;

    logic                in_acc;
    logic                cfg_wr;
    logic                out_free;
    logic [MODE_W-1:0]   in_mode;
    logic [NODE_W-1:0]   in_node;
    logic [NODE_W-1:0]   in_value;
    logic [NODE_W-1:0]   eff_cnt;

    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [NODE_W-1:0]   ram_wdata;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [NODE_W-1:0]   ram_rdata;

    kal_ram #(
        .WIDTH (NODE_W),
        .DEPTH (RAM_DEPTH)
    ) u_jump_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_mode  = s_axis_tuser;
    assign in_node  = s_axis_tdata[NODE_W-1:0];
    assign in_value = s_axis_tdata[2*NODE_W-1:NODE_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // APB: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_NODE_COUNT);
    assign prdata = (paddr[2] == REG_NODE_COUNT) ?
                    {{(APB_DW-NODE_W){1'b0}}, r_node_count} : '0;

    // Nodes at or above MAX_NODES never take part
    assign eff_cnt = (32'(r_node_count) < 32'(MAX_NODES - 1)) ?
                     r_node_count : NODE_W'(MAX_NODES - 1);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{(M_TDATA_W-NODE_W-1){1'b0}}, (r_out_anc != '0), r_out_anc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_node_count  <= NODE_W'(1);
            r_table_ready <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_node_count  <= n_node_count;
            r_table_ready <= n_table_ready;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_j        <= n_j;
        r_a        <= n_a;
        r_k        <= n_k;
        r_res_kind <= n_res_kind;
        r_out_kind <= n_out_kind;
        r_out_anc  <= n_out_anc;
    end

    always_comb begin
        n_state       = r_state;
        n_node_count  = r_node_count;
        n_table_ready = r_table_ready;
        n_lvl         = r_lvl;
        n_j           = r_j;
        n_a           = r_a;
        n_k           = r_k;
        n_res_kind    = r_res_kind;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_anc     = r_out_anc;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        // drop the output once the transfer completes
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_mode)
                        MODE_LOAD: begin
                            n_table_ready = 1'b0;
                            if (in_node >= NODE_W'(2) && in_node <= eff_cnt) begin
                                ram_we    = 1'b1;
                                ram_waddr = ram_addr('0, in_node);
                                ram_wdata = in_value;
                            end
                        end
                        MODE_BUILD: begin
                            n_j     = '0;
                            n_state = S_B0_RD;
                        end
                        MODE_QUERY: begin
                            n_res_kind = KIND_ANSWER;
                            if (r_table_ready && in_node != '0 && in_node <= eff_cnt) begin
                                n_a     = in_node;
                                n_k     = in_value;
                                n_lvl   = '0;
                                n_state = S_Q;
                            end else begin
                                n_a     = '0;
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // level 0 fix-up: root and node 0 get no parent, clamp stray parents
            S_B0_RD: begin
                ram_raddr = ram_addr('0, r_j);
                n_state   = S_B0_WR;
            end
            S_B0_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ram_addr('0, r_j);
                ram_wdata = (r_j < NODE_W'(2) || ram_rdata > eff_cnt) ? '0 : ram_rdata;
                if (r_j == eff_cnt) begin
                    n_lvl   = LVL_W'(1);
                    n_j     = '0;
                    n_state = S_BA;
                end else begin
                    n_j     = r_j + NODE_W'(1);
                    n_state = S_B0_RD;
                end
            end
            // level i entry j = level i-1 applied twice
            S_BA: begin
                ram_raddr = ram_addr(r_lvl - LVL_W'(1), r_j);
                n_state   = S_BB;
            end
            S_BB: begin
                ram_raddr = ram_addr(r_lvl - LVL_W'(1), ram_rdata);
                n_state   = S_BC;
            end
            S_BC: begin
                ram_we    = 1'b1;
                ram_waddr = ram_addr(r_lvl, r_j);
                ram_wdata = ram_rdata;
                if (r_j == eff_cnt) begin
                    if (r_lvl == LVL_W'(TOP)) begin
                        n_table_ready = 1'b1;
                        n_a           = '0;
                        n_res_kind    = KIND_BUILD;
                        n_state       = S_OUT;
                    end else begin
                        n_lvl   = r_lvl + LVL_W'(1);
                        n_j     = '0;
                        n_state = S_BA;
                    end
                end else begin
                    n_j     = r_j + NODE_W'(1);
                    n_state = S_BA;
                end
            end
            // climb: one jump per set bit, then repeat the top level for the high part
            S_Q: begin
                priority if (r_a == '0 || (r_lvl == LVL_W'(TOP) && r_k == '0)) begin
                    n_state = S_OUT;
                end else if (r_lvl == LVL_W'(TOP)) begin
                    ram_raddr = ram_addr(r_lvl, r_a);
                    n_k       = r_k - NODE_W'(1);
                    n_state   = S_QW;
                end else begin
                    if (r_k[0]) begin
                        ram_raddr = ram_addr(r_lvl, r_a);
                        n_state   = S_QW;
                    end
                    n_k   = r_k >> 1;
                    n_lvl = r_lvl + LVL_W'(1);
                end
            end
            S_QW: begin
                n_a     = ram_rdata;
                n_state = S_Q;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_anc   = r_a;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new node count invalidates the table
        if (cfg_wr) begin
            n_node_count  = pwdata[NODE_W-1:0];
            n_table_ready = 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_mode == MODE_LOAD |=> !r_table_ready)
        else $error("table still marked ready after a load");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q || r_state == S_QW) |-> !ram_we)
        else $error("jump store written during a query");

    a_build_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_BUILD |-> m_axis_tdata[NODE_W:0] == '0)
        else $error("build result carries an ancestor");

    a_ready_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BC && $past(r_state) == S_BB && n_state == S_OUT |=> r_table_ready)
        else $error("table not ready after build finished");

    a_answer_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q |-> r_table_ready)
        else $error("climb running without a built table");
`endif

endmodule
